>>> src/i2a_pkg.sv
// Shared types, register indexes and the digit table lookup for the radix converter.
package i2a_pkg;

  // Width of the input value port
  localparam int IN_BITS = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_RADIX    = 2'd0;
  localparam logic [1:0] CFG_CHARS_LO = 2'd1;
  localparam logic [1:0] CFG_CHARS_HI = 2'd2;

  // Reset values of the configuration registers
  localparam logic [4:0]  RADIX_RST    = 5'd16;
  localparam logic [63:0] CHARS_LO_RST = 64'h3736353433323130;
  localparam logic [63:0] CHARS_HI_RST = 64'h6665646362613938;

  // Status of the head of the front queue, seen by the back end
  typedef struct packed {
    logic valid;
    logic zero;
  } fe_status_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_RD,
    BK_LD,
    BK_EMIT
  } bk_state_t;

  // Look up the character for one digit in the sixteen-entry table
  function automatic logic [7:0] digit_char(input logic [63:0] lo,
                                            input logic [63:0] hi,
                                            input logic [3:0]  d);
    logic [127:0] tbl;
    tbl = {hi, lo};
    return tbl[{d, 3'b000} +: 8];
  endfunction

endpackage

>>> src/i2a_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module i2a_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/i2a_front.sv
// Front end: accepts input values, flags zero and queues them in a two-entry FIFO.
module i2a_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [i2a_pkg::IN_BITS-1:0] in_value,
  output logic [VALUE_BITS-1:0]       fe_value,
  output i2a_pkg::fe_status_t         fe_st,
  input  logic                        fe_pop
);

  import i2a_pkg::*;

  logic [VALUE_BITS-1:0] val_r [2];
  logic                  zero_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] in_masked;
  logic                  push;

  // Keep only the value bits the converter works on
  assign in_masked = VALUE_BITS'(in_value);

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = fe_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(fe_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_r[wr_ptr_r]  <= in_masked;
      zero_r[wr_ptr_r] <= (in_masked == '0);
    end
  end

  assign fe_value    = val_r[rd_ptr_r];
  assign fe_st.valid = (cnt_r != 2'd0);
  assign fe_st.zero  = zero_r[rd_ptr_r];

endmodule

>>> src/i2a_back.sv
// Back end: digit-serial division into the digit RAM, then reverse readout to the output.
module i2a_back #(
  parameter int VALUE_BITS = 32,
  parameter int TABLE_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] fe_value,
  input  i2a_pkg::fe_status_t   fe_st,
  output logic                  fe_pop,
  input  logic [4:0]            radix,
  input  logic [63:0]           chars_lo,
  input  logic [63:0]           chars_hi,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_character,
  output logic                  out_last
);

  import i2a_pkg::*;

  localparam int CHUNKS = (VALUE_BITS + 7) / 8;
  localparam int QW     = CHUNKS * 8;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW     = $clog2(VALUE_BITS);
  localparam int NW     = $clog2(VALUE_BITS + 1);

  bk_state_t       state_r, state_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic [3:0]      rem_r, rem_nxt;
  logic [CW-1:0]   chunk_r, chunk_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;

  logic [4:0]      base;
  logic [3:0]      rem_w;
  logic [4:0]      trial;
  logic [7:0]      qbits;
  logic [QW-1:0]   q_shift;
  logic            last_chunk;
  logic            conv_done;
  logic            load;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [3:0]      wr_data, rd_data;

  // Clamp the radix register to the usable range
  always_comb begin
    if (radix < 5'd2) begin
      base = 5'd2;
    end else if (radix > 5'(TABLE_SIZE)) begin
      base = 5'(TABLE_SIZE);
    end else begin
      base = radix;
    end
  end

  // Eight restoring-division steps per cycle on the top byte of the quotient register
  always_comb begin
    rem_w = rem_r;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < 8; i++) begin
      trial        = {rem_w, q_r[QW-1-i]};
      qbits[7-i]   = (trial >= base);
      rem_w        = (trial >= base) ? 4'(trial - base) : trial[3:0];
    end
  end

  assign q_shift    = (q_r << 8) | QW'(qbits);
  assign last_chunk = (chunk_r == CW'(CHUNKS - 1));
  assign conv_done  = last_chunk && ((q_shift == '0) || (cnt_r == NW'(VALUE_BITS - 1)));
  assign load       = (state_r == BK_LD) ||
                      ((state_r == BK_EMIT) && !out_stall && !out_last_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (fe_st.valid) begin
          state_nxt = fe_st.zero ? BK_RD : BK_DIV;
        end
      end
      BK_DIV: begin
        if (conv_done) begin
          state_nxt = BK_RD;
        end
      end
      BK_RD:   state_nxt = BK_LD;
      BK_LD:   state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (!out_stall && out_last_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    fe_pop        = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = rem_w;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    case (state_r)
      BK_IDLE: begin
        fe_pop = fe_st.valid;
        if (fe_st.valid) begin
          q_nxt     = QW'(fe_value);
          rem_nxt   = '0;
          chunk_nxt = '0;
          cnt_nxt   = fe_st.zero ? NW'(1) : '0;
          // Zero is a single digit 0: write it straight away
          wr_en     = fe_st.zero;
          wr_addr   = '0;
          wr_data   = '0;
        end
      end
      BK_DIV: begin
        q_nxt = q_shift;
        if (last_chunk) begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + NW'(1);
          chunk_nxt = '0;
          rem_nxt   = '0;
        end else begin
          chunk_nxt = chunk_r + CW'(1);
          rem_nxt   = rem_w;
        end
      end
      BK_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_r - NW'(1));
        idx_nxt = AW'(cnt_r - NW'(1));
      end
      BK_LD, BK_EMIT: begin
        if (state_r == BK_EMIT && !out_stall && out_last_r) begin
          out_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    // Present the fetched digit and prefetch the next one down
    if (load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = digit_char(chars_lo, chars_hi, rd_data);
      out_last_nxt  = (idx_r == '0);
      if (idx_r != '0) begin
        rd_en   = 1'b1;
        rd_addr = idx_r - AW'(1);
        idx_nxt = idx_r - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      chunk_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  i2a_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

>>> src/int_to_ascii_table_radix_top.sv
// Top level of the table-driven radix integer-to-text converter.
//
// Usage: present an unsigned value on in_value with in_valid; it transfers on a
// rising edge with in_valid high and in_stall low. Each value gives one
// character per digit on out_character, most significant first, with out_last
// set on the least significant one; a character transfers when out_valid is
// high and out_stall is low. Zero gives the single character for digit 0.
// Configuration (radix, digit table) is written through cfg_we/cfg_index/
// cfg_wdata while the block is idle; radix below 2 acts as 2, above the table
// size as the table size.
// Flow: a two-entry queue sits between the input and the converter. The
// divider makes 8 quotient bits per cycle through one shared remainder unit,
// one digit after another; the digits are then read back from the digit RAM
// (states BK_RD and BK_LD) and sent as one character per cycle while
// out_stall is low. Zero skips the divider.
// A stalled character holds on the output register and the readout waits; the
// queue keeps taking values until it is full. Reset (synchronous, rst_n low)
// empties the queue and output and restores the default radix 16 and table.
module int_to_ascii_table_radix_top #(
  parameter int VALUE_BITS = 32,
  parameter int TABLE_SIZE = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [i2a_pkg::IN_BITS-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_character,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [63:0]                 cfg_wdata
);

  import i2a_pkg::*;

  logic [4:0]            radix_r;
  logic [63:0]           chars_lo_r;
  logic [63:0]           chars_hi_r;
  logic [VALUE_BITS-1:0] fe_value;
  fe_status_t            fe_st;
  logic                  fe_pop;

  // Configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RST;
      chars_lo_r <= CHARS_LO_RST;
      chars_hi_r <= CHARS_HI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:    radix_r    <= cfg_wdata[4:0];
        CFG_CHARS_LO: chars_lo_r <= cfg_wdata;
        CFG_CHARS_HI: chars_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: take the transfer and queue the value
  i2a_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .fe_value (fe_value),
    .fe_st    (fe_st),
    .fe_pop   (fe_pop)
  );

  // Back end: convert one queued value and stream out its characters
  i2a_back #(
    .VALUE_BITS (VALUE_BITS),
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fe_value      (fe_value),
    .fe_st         (fe_st),
    .fe_pop        (fe_pop),
    .radix         (radix_r),
    .chars_lo      (chars_lo_r),
    .chars_hi      (chars_hi_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

`ifndef ASSERT_OFF
  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fe_pop |-> fe_st.valid)
    else $error("queue popped while empty");

  // A full queue must present a valid head
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> fe_st.valid)
    else $error("input stalled with empty queue");

  // No new value starts while characters are still being delivered
  a_no_pop_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !fe_pop)
    else $error("value popped during readout");

  // After the final character transfers, the output empties
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> !out_valid)
    else $error("output still valid after last character");
`endif

endmodule

>>> dv/int_to_ascii_table_radix_top_tb.sv
// Self-checking testbench for the table-driven radix integer-to-text converter.
`timescale 1ns / 100ps

module int_to_ascii_table_radix_top_tb;
  import i2a_pkg::*;

  // Run ends here whatever happens; the slowest correct run is a small fraction of it.
  localparam int unsigned RUN_LIMIT_NS = 15_000_000;
  localparam int          N_STEPS      = 33;
  localparam int          N_PHASES     = 8;
  localparam int          PHASE_ITEMS  = 44;

  typedef enum logic {ROW_CFG, ROW_VALUE} row_kind_t;

  // One row of the directed table: a register write or a value to convert.
  // An empty text means the expected characters come from the predictor.
  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [63:0] data;
    string       text;
  } step_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [31:0] in_value  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_character;
  logic        out_last;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_RADIX;
  logic [63:0] cfg_wdata = '0;

  // Predictor copy of the configuration registers
  logic [4:0]  radix_reg = RADIX_RST;
  logic [63:0] chars_lo  = CHARS_LO_RST;
  logic [63:0] chars_hi  = CHARS_HI_RST;

  text_char_t  chars_due[$];   // characters still owed by the block, oldest first
  int          err_count = 0;
  bit          steady    = 1'b0; // set to switch off idling on both sides

  // Directed stimulus. Literal text only where it can be read off directly.
  step_t steps [N_STEPS] = '{
    // reset table, base 16
    '{ROW_VALUE, CFG_RADIX,    64'h0,                "0"},
    '{ROW_VALUE, CFG_RADIX,    64'hFFFF_FFFF,        "ffffffff"},
    '{ROW_VALUE, CFG_RADIX,    64'h1,                "1"},
    '{ROW_VALUE, CFG_RADIX,    64'h8000_0000,        "80000000"},
    '{ROW_VALUE, CFG_RADIX,    64'h1234_5678,        ""},
    '{ROW_VALUE, CFG_RADIX,    64'h10,               "10"},
    // base 2: longest outputs
    '{ROW_CFG,   CFG_RADIX,    64'd2,                ""},
    '{ROW_VALUE, CFG_RADIX,    64'hFFFF_FFFF,        "11111111111111111111111111111111"},
    '{ROW_VALUE, CFG_RADIX,    64'h0,                "0"},
    '{ROW_VALUE, CFG_RADIX,    64'h8000_0000,        "10000000000000000000000000000000"},
    // base 10
    '{ROW_CFG,   CFG_RADIX,    64'd10,               ""},
    '{ROW_VALUE, CFG_RADIX,    64'hFFFF_FFFF,        "4294967295"},
    '{ROW_VALUE, CFG_RADIX,    64'd1000000000,       ""},
    '{ROW_VALUE, CFG_RADIX,    64'd9,                ""},
    // radix below two behaves as base 2
    '{ROW_CFG,   CFG_RADIX,    64'd0,                ""},
    '{ROW_VALUE, CFG_RADIX,    64'd5,                "101"},
    '{ROW_CFG,   CFG_RADIX,    64'd1,                ""},
    '{ROW_VALUE, CFG_RADIX,    64'd6,                "110"},
    // radix above the table behaves as base 16
    '{ROW_CFG,   CFG_RADIX,    64'd31,               ""},
    '{ROW_VALUE, CFG_RADIX,    64'hDEAD_BEEF,        "deadbeef"},
    // junk above the five radix bits is dropped: 0x11 acts as 17, so 16
    '{ROW_CFG,   CFG_RADIX,    64'hFFFF_FFFF_FFFF_FF11, ""},
    '{ROW_VALUE, CFG_RADIX,    64'd255,              "ff"},
    // zero bytes and duplicate 0xff characters in the table
    '{ROW_CFG,   CFG_CHARS_LO, 64'h0,                ""},
    '{ROW_CFG,   CFG_CHARS_HI, 64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{ROW_VALUE, CFG_RADIX,    64'h89AB_CDEF,        ""},
    '{ROW_VALUE, CFG_RADIX,    64'h0123_4567,        ""},
    // odd bases with a letter table
    '{ROW_CFG,   CFG_RADIX,    64'd3,                ""},
    '{ROW_CFG,   CFG_CHARS_LO, 64'h4847_4645_4443_4241, ""},
    '{ROW_CFG,   CFG_CHARS_HI, 64'h504F_4E4D_4C4B_4A49, ""},
    '{ROW_VALUE, CFG_RADIX,    64'hFFFF_FFFF,        ""},
    '{ROW_CFG,   CFG_RADIX,    64'd15,               ""},
    '{ROW_VALUE, CFG_RADIX,    64'hFFFF_FFFF,        ""},
    '{ROW_VALUE, CFG_RADIX,    64'd14,               ""}
  };

  int_to_ascii_table_radix_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Base actually in use: clamp the radix register into 2..16.
  function automatic int eff_base();
    int b;
    b = radix_reg;
    if (b < 2) b = 2;
    if (b > 16) b = 16;
    return b;
  endfunction

  // Spell a value in the current base and queue its characters, most
  // significant first, with last on the units digit.
  function automatic void spell_value(input logic [31:0] v);
    logic [3:0]   digs [32];
    logic [127:0] tbl;
    logic [31:0]  rest;
    int           base;
    int           n;
    base = eff_base();
    tbl  = {chars_hi, chars_lo};
    rest = v;
    n    = 0;
    do begin
      digs[n] = 4'(rest % base);
      rest    = rest / base;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--)
      chars_due.push_back('{tbl[8*digs[k] +: 8], k == 0});
  endfunction

  // Random value, biased towards small numbers and the edges of digit counts
  // (powers of the base and one below them).
  function automatic logic [31:0] pick_value(input int base);
    logic [63:0] p;
    int          k;
    p = 64'd1;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 40);
      3: return $urandom >> $urandom_range(0, 31);
      default: begin
        repeat (k) if (p * base <= 64'hFFFF_FFFF) p = p * base;
        return p[31:0] - $urandom_range(0, 1);
      end
    endcase
  endfunction

  // Write one register; entered and left on a rising edge. The enable is raised
  // and dropped with nonblocking writes, so back-to-back writes never clash within a time step.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_RADIX:    radix_reg = data[4:0];
      CFG_CHARS_LO: chars_lo  = data;
      CFG_CHARS_HI: chars_hi  = data;
      default: ;
    endcase
  endtask

  // Offer one value and hold it until it transfers, then log what it owes.
  // Valid stays high between back-to-back values; idle gaps drop it.
  task automatic send_value(input logic [31:0] v, input string text);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    if (text.len() == 0) begin
      spell_value(v);
    end else begin
      for (int i = 0; i < text.len(); i++)
        chars_due.push_back('{text[i], i == text.len() - 1});
    end
  endtask

  // Drop valid and wait until every owed character has arrived, plus a few
  // cycles so the block is idle before the registers change.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result side: check each transfer against the oldest owed character, then
  // pick the stall for the next cycle.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chars_due.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, out_character, out_last);
        err_count++;
      end else begin
        want = chars_due.pop_front();
        if (out_character !== want.ch) begin
          $display("%0t: wrong character: expected %h, actual %h",
                   $time, want.ch, out_character);
          err_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: wrong last flag: expected %b, actual %b",
                   $time, want.last, out_last);
          err_count++;
        end
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 33);
  end

  initial begin
    int          base;
    logic [63:0] word;
    // hold reset, then release it synchronously
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Registers change only with the block drained.
    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(steps[i].idx, steps[i].data);
      end else begin
        send_value(steps[i].data[31:0], steps[i].text);
      end
    end

    // Random phases: a fresh setting each, extremes of the radix first.
    // Phase three runs without idling on either side.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      steady = (ph == 3);
      word = {$urandom, $urandom};
      case (ph)
        0:       word[4:0] = 5'd2;
        1:       word[4:0] = 5'd16;
        2:       word[4:0] = 5'd0;
        4:       word[4:0] = 5'd31;
        default: word[4:0] = 5'($urandom_range(0, 31));
      endcase
      write_reg(CFG_RADIX, word);
      // alternate between a random table and the reset table
      write_reg(CFG_CHARS_LO, ph[0] ? {$urandom, $urandom} : CHARS_LO_RST);
      write_reg(CFG_CHARS_HI, ph[0] ? {$urandom, $urandom} : CHARS_HI_RST);
      base = eff_base();
      repeat (PHASE_ITEMS) send_value(pick_value(base), "");
    end

    // Wait for the last characters, then give stray output time to show.
    steady = 1'b0;
    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0)
      $display("int_to_ascii_table_radix_top: match");
    else
      $display("int_to_ascii_table_radix_top: mismatch");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT_NS);
    $display("int_to_ascii_table_radix_top: mismatch");
    $finish;
  end

endmodule

>>> sim.f
src/i2a_pkg.sv
src/i2a_ram.sv
src/i2a_front.sv
src/i2a_back.sv
src/int_to_ascii_table_radix_top.sv
dv/int_to_ascii_table_radix_top_tb.sv
